>>> rtl/kscnt_pkg.sv
// ----------------------------------------------------------------------------
// kscnt_pkg
// Shared types and constants of the keyed statistics counter table.
// ----------------------------------------------------------------------------
package kscnt_pkg;

   localparam int unsigned BucketsDefault = 16;
   localparam int unsigned WaysDefault    = 4;
   localparam int unsigned DrainLimit     = 64;
   localparam int unsigned DrainCntW      = 7;

   localparam logic [1:0] ModeAdd   = 2'd0;
   localparam logic [1:0] ModeMax   = 2'd1;
   localparam logic [1:0] ModeDrain = 2'd2;
   localparam logic [1:0] ModeNone  = 2'd3;

   localparam logic [1:0] StUpdated = 2'd0;
   localparam logic [1:0] StFull    = 2'd1;
   localparam logic [1:0] StDrained = 2'd2;
   localparam logic [1:0] StEmpty   = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] key;
      logic [31:0] value;
   } cmd_type;

   typedef struct packed {
      logic [31:0] out_key;
      logic [31:0] count;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

endpackage

>>> rtl/keyed_statistics_counter_table_top.sv
// ----------------------------------------------------------------------------
// keyed_statistics_counter_table_top
// Table of keyed signed 32-bit counters with add, max and drain commands.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// req_     in   req_tvalid/tready     tdata {value, key, mode}
// rsp_     out  rsp_tvalid/tready     tdata {status, count, out_key}, tlast
// Add or max: accept, bucket hash, one RAM read per way, then the write.
// Drain: accept, then a read and an evaluation per slot walked, over up to
// BUCKETS*WAYS slots or until DrainLimit counters have been drained.
// After reset a clearing pass writes all BUCKETS*WAYS slots before any command runs.
// A two-entry command queue and the result register let each side stall.
// ----------------------------------------------------------------------------
module keyed_statistics_counter_table_top #(
   parameter int unsigned BUCKETS = kscnt_pkg::BucketsDefault,
   parameter int unsigned WAYS    = kscnt_pkg::WaysDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // mode[1:0], key[33:2], value[65:34], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_key[31:0], count[63:32], status[65:64], zero pad
   output logic        rsp_tlast
);

   kscnt_pkg::cmd_type in_cmd, q_cmd;
   kscnt_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   assign in_cmd = '{req_tdata[1:0], req_tdata[33:2], req_tdata[65:34]};

   kscnt_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
   );

   kscnt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {6'd0, rsp.status, rsp.count, rsp.out_key};
   assign rsp_tlast = rsp.last;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65:64] == kscnt_pkg::StFull |-> rsp_tdata[63:32] == 32'd0 && rsp_tlast)
      else $error("dropped update carries a count");
   a_drain_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65:64] == kscnt_pkg::StDrained |-> !rsp_tdata[63] && rsp_tdata[63:32] != 32'd0)
      else $error("drained a non-positive counter");

endmodule

>>> rtl/kscnt_ram.sv
// ----------------------------------------------------------------------------
// kscnt_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module kscnt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> rtl/kscnt_front.sv
// ----------------------------------------------------------------------------
// kscnt_front
// Input stage: accepts commands, drops unused modes, queues the rest.
// ----------------------------------------------------------------------------
module kscnt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  kscnt_pkg::cmd_type in_cmd,
   output logic              q_valid,
   input  logic              q_ready,
   output kscnt_pkg::cmd_type q_cmd
);

   // two-entry queue
   kscnt_pkg::cmd_type buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rp_ff, rp_in, wp_ff, wp_in;
   logic       push, pop, keep;

   assign in_ready = (cnt_ff != 2'd2);
   assign keep     = (in_cmd.mode == kscnt_pkg::ModeAdd) ||
                     (in_cmd.mode == kscnt_pkg::ModeMax) ||
                     (in_cmd.mode == kscnt_pkg::ModeDrain);
   assign push     = in_valid && in_ready && keep;
   assign q_valid  = (cnt_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = buf_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      rp_in  = rp_ff ^ pop;
      wp_in  = wp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         rp_ff  <= 1'b0;
         wp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rp_ff  <= rp_in;
         wp_ff  <= wp_in;
      end
      if (push) begin
         buf_ff[wp_ff] <= in_cmd;
      end
   end

endmodule

>>> rtl/kscnt_back.sv
// ----------------------------------------------------------------------------
// kscnt_back
// Execution engine: bucket lookup, update, drain walk and result register.
// ----------------------------------------------------------------------------
module kscnt_back #(
   parameter int unsigned BUCKETS = kscnt_pkg::BucketsDefault,
   parameter int unsigned WAYS    = kscnt_pkg::WaysDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  kscnt_pkg::cmd_type q_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output kscnt_pkg::rsp_type out_rsp
);

   localparam int unsigned Slots = BUCKETS * WAYS;
   localparam int unsigned SW    = (Slots > 1) ? $clog2(Slots) : 1;
   localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned VW    = $clog2(Slots + 1);
   // key mod BUCKETS: quotient by reciprocal multiply, exact for 32-bit keys
   localparam int unsigned LB    = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
   localparam logic [63:0] RecipWide =
      ((64'd1 << (32 + LB)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
   localparam logic [32:0] Recip = RecipWide[32:0];

   typedef enum logic [7:0] {
      S_IDLE  = 8'b00000001,
      S_CLEAR = 8'b00000010,
      S_HASH  = 8'b00000100,
      S_LOOK  = 8'b00001000,
      S_EVAL  = 8'b00010000,
      S_DRD   = 8'b00100000,
      S_DEV   = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;
   kscnt_pkg::cmd_type cmd_ff;
   logic [64:0]   prod_ff;
   logic [SW-1:0] clr_ff, clr_in;
   logic [BW-1:0] bkt_ff, bkt_in;
   logic [WW-1:0] way_ff, way_in;
   logic [VW-1:0] slot_ff, slot_in;
   logic [kscnt_pkg::DrainCntW-1:0] n_ff, n_in;
   logic          hit_fnd_ff, hit_fnd_in, free_fnd_ff, free_fnd_in;
   logic [WW-1:0] hit_w_ff, hit_w_in, free_w_ff, free_w_in;
   logic [31:0]   hit_c_ff, hit_c_in;
   logic          pend_ff, pend_in;
   kscnt_pkg::rsp_type pend_rsp_ff, pend_rsp_in;
   kscnt_pkg::rsp_type hold_rsp_ff, hold_rsp_in;
   logic          ov_ff, ov_in;
   kscnt_pkg::rsp_type ord_ff, ord_in;

   // entry RAM: {valid, key, count}
   logic          wr_en;
   logic [SW-1:0] wr_addr, rd_addr;
   logic [64:0]   wr_data, rd_data;

   kscnt_ram #(.WIDTH(65), .DEPTH(Slots)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic          rvalid;
   logic [31:0]   rkey, rcnt;
   logic [31:0]   quot, hrem;
   logic [31:0]   newc;
   logic [WW-1:0] sel_w;
   logic          positive;

   assign rvalid   = rd_data[64];
   assign rkey     = rd_data[63:32];
   assign rcnt     = rd_data[31:0];
   assign positive = rvalid && (rcnt != 32'd0) && !rcnt[31];
   assign out_valid = ov_ff;
   assign out_rsp   = ord_ff;
   assign q_ready   = (state_ff == S_IDLE);

   function automatic logic [SW-1:0] addr_of(input logic [BW-1:0] b, input logic [WW-1:0] w);
      addr_of = SW'(32'(b) * WAYS + 32'(w));
   endfunction

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      bkt_in      = bkt_ff;
      way_in      = way_ff;
      slot_in     = slot_ff;
      n_in        = n_ff;
      hit_fnd_in  = hit_fnd_ff;
      free_fnd_in = free_fnd_ff;
      hit_w_in    = hit_w_ff;
      free_w_in   = free_w_ff;
      hit_c_in    = hit_c_ff;
      pend_in     = pend_ff;
      pend_rsp_in = pend_rsp_ff;
      hold_rsp_in = hold_rsp_ff;
      ov_in       = ov_ff && !out_ready;
      ord_in      = ord_ff;
      wr_en       = 1'b0;
      wr_addr     = clr_ff;
      wr_data     = '0;
      rd_addr     = addr_of(bkt_ff, way_ff);
      quot        = '0;
      hrem        = '0;
      newc        = '0;
      sel_w       = '0;

      // move pending result into the output register
      if (pend_ff && !ov_in) begin
         ov_in   = 1'b1;
         ord_in  = pend_rsp_ff;
         pend_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == Slots - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               way_in      = '0;
               slot_in     = '0;
               n_in        = '0;
               hit_fnd_in  = 1'b0;
               free_fnd_in = 1'b0;
               if (q_cmd.mode == kscnt_pkg::ModeDrain) begin
                  bkt_in   = '0;
                  rd_addr  = addr_of('0, '0);
                  state_in = S_DEV;
               end else begin
                  state_in = S_HASH;
               end
            end
         end
         S_HASH: begin
            // prod_ff holds key * Recip
            quot     = 32'(prod_ff >> (32 + LB));
            hrem     = cmd_ff.key - quot * BUCKETS;
            bkt_in   = BW'(hrem);
            rd_addr  = addr_of(bkt_in, '0);
            state_in = S_LOOK;
         end
         S_LOOK: begin
            // rd_data holds way way_ff
            if (rvalid) begin
               if (!hit_fnd_ff && rkey == cmd_ff.key) begin
                  hit_fnd_in = 1'b1;
                  hit_w_in   = way_ff;
                  hit_c_in   = rcnt;
               end
            end else if (!free_fnd_ff) begin
               free_fnd_in = 1'b1;
               free_w_in   = way_ff;
            end
            if (32'(way_ff) == WAYS - 1) begin
               state_in = S_EVAL;
            end else begin
               way_in  = way_ff + 1'b1;
               rd_addr = addr_of(bkt_ff, way_in);
            end
         end
         S_EVAL: begin
            if (!pend_in) begin
               if (!hit_fnd_ff && !free_fnd_ff) begin
                  pend_rsp_in = '{cmd_ff.key, 32'd0, kscnt_pkg::StFull, 1'b1};
               end else begin
                  logic [31:0] base;
                  base  = hit_fnd_ff ? hit_c_ff : 32'd0;
                  sel_w = hit_fnd_ff ? hit_w_ff : free_w_ff;
                  if (cmd_ff.mode == kscnt_pkg::ModeAdd) begin
                     newc = base + cmd_ff.value;
                  end else begin
                     newc = ($signed(cmd_ff.value) > $signed(base)) ? cmd_ff.value : base;
                  end
                  wr_en   = 1'b1;
                  wr_addr = addr_of(bkt_ff, sel_w);
                  wr_data = {1'b1, cmd_ff.key, newc};
                  pend_rsp_in = '{cmd_ff.key, newc, kscnt_pkg::StUpdated, 1'b1};
               end
               pend_in  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DEV: begin
            // rd_data holds slot slot_ff; the latest drained entry waits in
            // hold_rsp_ff until it is known whether it is the final one
            if (32'(slot_ff) == Slots || 32'(n_ff) == kscnt_pkg::DrainLimit) begin
               if (!pend_in) begin
                  if (n_ff == '0) begin
                     pend_rsp_in = '{32'd0, 32'd0, kscnt_pkg::StEmpty, 1'b1};
                  end else begin
                     pend_rsp_in      = hold_rsp_ff;
                     pend_rsp_in.last = 1'b1;
                  end
                  pend_in  = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (positive) begin
               if (!pend_in) begin
                  if (n_ff != '0) begin
                     pend_rsp_in = hold_rsp_ff;
                     pend_in     = 1'b1;
                  end
                  hold_rsp_in = '{rkey, rcnt, kscnt_pkg::StDrained, 1'b0};
                  wr_en   = 1'b1;
                  wr_addr = SW'(slot_ff);
                  wr_data = {1'b1, rkey, 32'd0};
                  n_in    = n_ff + 1'b1;
                  slot_in = slot_ff + 1'b1;
                  rd_addr = SW'(slot_in);
                  state_in = S_DRD;
               end else begin
                  rd_addr = SW'(slot_ff);
               end
            end else begin
               slot_in  = slot_ff + 1'b1;
               rd_addr  = SW'(slot_in);
               state_in = S_DRD;
            end
         end
         S_DRD: begin
            // wait state for the registered read of slot_ff
            rd_addr  = SW'(slot_ff);
            state_in = S_DEV;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
         ov_ff    <= ov_in;
      end
      if (state_ff == S_IDLE && q_valid) begin
         cmd_ff  <= q_cmd;
         prod_ff <= 65'(q_cmd.key) * 65'(Recip);
      end
      bkt_ff      <= bkt_in;
      way_ff      <= way_in;
      slot_ff     <= slot_in;
      n_ff        <= n_in;
      hit_fnd_ff  <= hit_fnd_in;
      free_fnd_ff <= free_fnd_in;
      hit_w_ff    <= hit_w_in;
      free_w_ff   <= free_w_in;
      hit_c_ff    <= hit_c_in;
      pend_rsp_ff <= pend_rsp_in;
      hold_rsp_ff <= hold_rsp_in;
      ord_ff      <= ord_in;
   end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, max, drain and unused-mode commands into the counter table, keeps a local
// copy of the table, and compares every result transaction field by field.
// ----------------------------------------------------------------------------

class counter_scoreboard;
   localparam int NumBuckets = kscnt_pkg::BucketsDefault;
   localparam int NumWays    = kscnt_pkg::WaysDefault;
   localparam int NumSlots   = NumBuckets * NumWays;

   bit                 slot_used [NumSlots];
   logic [31:0]        slot_id   [NumSlots];
   logic [31:0]        slot_cnt  [NumSlots];
   kscnt_pkg::rsp_type pending_rsp [$];
   int                 errors;

   function void push(logic [31:0] k, logic [31:0] c, logic [1:0] st, logic l);
      kscnt_pkg::rsp_type r;
      r.out_key = k;
      r.count   = c;
      r.status  = st;
      r.last    = l;
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   function void note_command(kscnt_pkg::cmd_type c);
      int base, hit, free_slot, n;
      base = (c.key % NumBuckets) * NumWays;
      hit = -1;
      free_slot = -1;
      n = 0;
      if (c.mode == kscnt_pkg::ModeAdd || c.mode == kscnt_pkg::ModeMax) begin
         for (int w = 0; w < NumWays; w++) begin
            if (slot_used[base + w]) begin
               if (hit < 0 && slot_id[base + w] == c.key) hit = base + w;
            end else if (free_slot < 0) begin
               free_slot = base + w;
            end
         end
         if (hit < 0 && free_slot < 0) begin
            push(c.key, 32'd0, kscnt_pkg::StFull, 1'b1);
            return;
         end
         if (hit < 0) begin
            hit = free_slot;
            slot_used[hit] = 1'b1;
            slot_id[hit]   = c.key;
            slot_cnt[hit]  = '0;
         end
         if (c.mode == kscnt_pkg::ModeAdd) slot_cnt[hit] = slot_cnt[hit] + c.value;
         else if ($signed(c.value) > $signed(slot_cnt[hit])) slot_cnt[hit] = c.value;
         push(c.key, slot_cnt[hit], kscnt_pkg::StUpdated, 1'b1);
      end else if (c.mode == kscnt_pkg::ModeDrain) begin
         for (int s = 0; s < NumSlots && n < kscnt_pkg::DrainLimit; s++) begin
            if (slot_used[s] && $signed(slot_cnt[s]) > 0) begin
               push(slot_id[s], slot_cnt[s], kscnt_pkg::StDrained, 1'b0);
               slot_cnt[s] = '0;
               n++;
            end
         end
         if (n == 0) push(32'd0, 32'd0, kscnt_pkg::StEmpty, 1'b1);
         else pending_rsp[$].last = 1'b1;
      end
   endfunction

   function void check_result(logic [71:0] data, logic tlast);
      kscnt_pkg::rsp_type e;
      if (pending_rsp.size() == 0) begin
         $error("unexpected result transaction key=%h", data[31:0]);
         errors++;
         return;
      end
      e = pending_rsp.pop_front();
      if (data[31:0] !== e.out_key) begin
         $error("out_key expected %h actual %h", e.out_key, data[31:0]);
         errors++;
      end
      if (data[63:32] !== e.count) begin
         $error("count expected %h actual %h", e.count, data[63:32]);
         errors++;
      end
      if (data[65:64] !== e.status) begin
         $error("status expected %0d actual %0d", e.status, data[65:64]);
         errors++;
      end
      if (tlast !== e.last) begin
         $error("last expected %0d actual %0d", e.last, tlast);
         errors++;
      end
   endfunction
endclass

module testbench;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  recv_hold     = 1'b0;
   counter_scoreboard table_model = new();

   keyed_statistics_counter_table_top u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) table_model.check_result(rsp_tdata, rsp_tlast);
      rsp_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // tvalid stays up after an accept so back-to-back transactions need no gap
   task automatic send_command(logic [1:0] mode, logic [31:0] key, logic [31:0] value);
      kscnt_pkg::cmd_type c;
      c.mode  = mode;
      c.key   = key;
      c.value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, key, mode};
      do @(posedge clock); while (!req_tready);
      table_model.note_command(c);
   endtask

   // keys mostly from a small pool so buckets fill up and hits recur
   function automatic logic [31:0] pick_key();
      case ($urandom_range(3))
         0:       return $urandom;
         1:       return 32'hFFFF_FFF0 + $urandom_range(15);
         default: return $urandom_range(5) * 16 + $urandom_range(3);
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(4))
         0:       return $urandom;
         1:       return {1'b1, 31'($urandom)};
         2:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom_range(200) - 100;
      endcase
   endfunction

   task automatic random_phase(int n);
      int r;
      logic [1:0] m;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         m = r < 50 ? kscnt_pkg::ModeAdd : r < 85 ? kscnt_pkg::ModeMax :
             r < 97 ? kscnt_pkg::ModeDrain : kscnt_pkg::ModeNone;
         send_command(m, pick_key(), pick_value());
      end
   endtask

   task automatic wait_drained();
      while (table_model.pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // directed: empty drain, extremes, wrap, max, full bucket, unused mode
      send_command(kscnt_pkg::ModeDrain, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(kscnt_pkg::ModeAdd,   32'h0000_0000, 32'h7FFF_FFFF);
      send_command(kscnt_pkg::ModeAdd,   32'h0000_0000, 32'h0000_0001);
      send_command(kscnt_pkg::ModeAdd,   32'hFFFF_FFFF, 32'h8000_0000);
      send_command(kscnt_pkg::ModeMax,   32'hFFFF_FFFF, 32'h8000_0000);
      send_command(kscnt_pkg::ModeMax,   32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_command(kscnt_pkg::ModeMax,   32'h0000_0010, 32'hFFFF_FFFF);
      send_command(kscnt_pkg::ModeMax,   32'h0000_0020, 32'h0000_0005);
      send_command(kscnt_pkg::ModeAdd,   32'h0000_0030, 32'h0000_0000);
      send_command(kscnt_pkg::ModeAdd,   32'h0000_0040, 32'h0000_0003);
      send_command(kscnt_pkg::ModeMax,   32'h0000_0050, 32'h0000_0009);
      send_command(kscnt_pkg::ModeNone,  32'hAAAA_5555, 32'h5555_AAAA);
      send_command(kscnt_pkg::ModeAdd,   32'h0000_0020, 32'h0000_0002);
      send_command(kscnt_pkg::ModeDrain, 32'h0000_0000, 32'h0000_0000);
      send_command(kscnt_pkg::ModeDrain, 32'h5555_AAAA, 32'hAAAA_5555);

      send_idle_pct = 36; recv_idle_pct = 45;
      random_phase(55);
      send_idle_pct = 45; recv_idle_pct = 36;
      random_phase(55);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(30);
      // long receiver stall while commands keep coming
      fork
         begin
            recv_hold = 1'b1;
            repeat (400) @(posedge clock);
            recv_hold = 1'b0;
         end
         random_phase(20);
      join
      send_command(kscnt_pkg::ModeDrain, 32'h0, 32'h0);
      req_tvalid <= 1'b0;
      wait_drained();
      if (table_model.errors == 0) $display("[keyed_statistics_counter_table_top] OK");
      else $display("[keyed_statistics_counter_table_top] ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("[keyed_statistics_counter_table_top] ERROR");
      $finish;
   end
endmodule

>>> sim.f
rtl/kscnt_pkg.sv
rtl/kscnt_ram.sv
rtl/kscnt_front.sv
rtl/kscnt_back.sv
rtl/keyed_statistics_counter_table_top.sv
dv/testbench.sv
